// ----- src/wdct_pkg.sv -----
// ----------------------------------------------------------------------------
// wdct_pkg: shared types and constants
// Beat payloads, the front-to-back command, configuration view, opcodes,
// register indexes and the back end state encoding.
// ----------------------------------------------------------------------------
package wdct_pkg;

   localparam int DOC_ID_W    = 12;
   localparam int WEIGHT_W    = 32;
   localparam int COUNT_W     = 32;
   localparam int TOTAL_W     = 64;
   localparam int NUM_DOCS_W  = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DOCS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd2;

   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RST = 32'd1;
   localparam logic [NUM_DOCS_W-1:0] NUM_DOCS_RST  = 13'd4096;
   localparam logic                  MODE_RST      = 1'b0;

   typedef enum logic [1:0] {
      OP_ROW   = 2'd0,
      OP_DOC   = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } wdct_op_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } wdct_state_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [DOC_ID_W-1:0] doc_id;
      logic [WEIGHT_W-1:0] weight;
   } wdct_req_type;

   typedef struct packed {
      logic [DOC_ID_W-1:0] doc_index;
      logic                selected;
      logic [TOTAL_W-1:0]  score;
   } wdct_rsp_type;

   typedef struct packed {
      wdct_op_type         op;
      logic [DOC_ID_W-1:0] doc_id;
      logic                in_use;
      logic [WEIGHT_W-1:0] weight;
   } wdct_cmd_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] threshold;   // already forced to at least one
      logic [NUM_DOCS_W-1:0] num_docs;
      logic                  mode;
   } wdct_cfg_type;

endpackage

// ----- src/wdct_fifo.sv -----
// ----------------------------------------------------------------------------
// wdct_fifo: small register queue
// Circular buffer with occupancy count; head is shown while not empty.
// ----------------------------------------------------------------------------
module wdct_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     din,
   output logic full,
   input  logic pop,
   output T     dout,
   output logic empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   T                storage_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = storage_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         storage_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- src/wdct_front.sv -----
// ----------------------------------------------------------------------------
// wdct_front: input side
// Takes request beats, decodes the opcode, checks the document range and
// queues one command per beat for the back end.
// ----------------------------------------------------------------------------
module wdct_front #(
   parameter int MAX_DOCS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wdct_pkg::wdct_req_type req_data,
   output logic                  full,
   input  wdct_pkg::wdct_cfg_type cfg,
   input  logic                  init_busy,
   output wdct_pkg::wdct_cmd_type cmd,
   output logic                  cmd_valid,
   input  logic                  cmd_pop
);

   wdct_pkg::wdct_cmd_type cmd_new;
   logic                   q_full;
   logic                   q_empty;

   // an id is live only below both the programmed count and the array depth
   always_comb begin
      cmd_new.op     = wdct_pkg::wdct_op_type'(req_data.opcode);
      cmd_new.doc_id = req_data.doc_id;
      cmd_new.weight = req_data.weight;
      cmd_new.in_use = ({1'b0, req_data.doc_id} < cfg.num_docs) &&
                       (32'(req_data.doc_id) < 32'(MAX_DOCS));
   end

   assign full      = q_full || init_busy;
   assign cmd_valid = !q_empty;

   wdct_fifo #(
      .T     (wdct_pkg::wdct_cmd_type),
      .DEPTH (2)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push && !full),
      .din   (cmd_new),
      .full  (q_full),
      .pop   (cmd_pop),
      .dout  (cmd),
      .empty (q_empty)
   );

endmodule

// ----- src/wdct_back.sv -----
// ----------------------------------------------------------------------------
// wdct_back: execution side
// Owns the counter memory and the running total; does one read-modify-write
// per in-use document command, sweeps the memory on clear, queues query results.
// ----------------------------------------------------------------------------
module wdct_back #(
   parameter int MAX_DOCS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wdct_pkg::wdct_cfg_type cfg,
   input  wdct_pkg::wdct_cmd_type cmd,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   output logic                   init_busy,
   output wdct_pkg::wdct_rsp_type rsp_data,
   output logic                   empty,
   input  logic                   pop
);

   localparam int AW = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;

   logic [wdct_pkg::COUNT_W-1:0] mem [MAX_DOCS];

   wdct_pkg::wdct_state_type     state_ff, state_in;
   wdct_pkg::wdct_cmd_type       cur_ff, cur_in;
   logic [wdct_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [AW-1:0]                clr_addr_ff, clr_addr_in;
   logic                         init_ff, init_in;
   logic [wdct_pkg::COUNT_W-1:0] rd_data_ff;

   logic                         mem_we;
   logic [AW-1:0]                mem_wa;
   logic [wdct_pkg::COUNT_W-1:0] mem_wd;
   logic [AW-1:0]                mem_ra;

   logic                         res_push;
   logic                         res_full;
   wdct_pkg::wdct_rsp_type       res;
   logic [wdct_pkg::TOTAL_W-1:0] score;

   assign init_busy = init_ff;
   assign mem_ra    = AW'(cmd.doc_id);

   always_comb begin
      score = cfg.mode ? (total_ff - 64'(rd_data_ff)) : 64'(rd_data_ff);
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      total_in    = total_ff;
      clr_addr_in = clr_addr_ff;
      init_in     = init_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = AW'(cur_ff.doc_id);
      mem_wd      = '0;
      res_push    = 1'b0;
      res         = '0;
      unique case (state_ff)
         wdct_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cur_in = cmd;
               unique case (cmd.op)
                  wdct_pkg::OP_ROW: begin
                     cmd_pop  = 1'b1;
                     total_in = total_ff + 64'(cmd.weight);
                  end
                  wdct_pkg::OP_DOC: begin
                     cmd_pop = 1'b1;
                     if (cmd.in_use) begin
                        state_in = wdct_pkg::BK_EXEC;
                     end
                  end
                  wdct_pkg::OP_QUERY: begin
                     // hold the command until the result has a slot
                     if (!res_full) begin
                        cmd_pop = 1'b1;
                        if (cmd.in_use) begin
                           state_in = wdct_pkg::BK_EXEC;
                        end else begin
                           res_push      = 1'b1;
                           res.doc_index = cmd.doc_id;
                        end
                     end
                  end
                  wdct_pkg::OP_CLEAR: begin
                     cmd_pop     = 1'b1;
                     total_in    = '0;
                     clr_addr_in = '0;
                     state_in    = wdct_pkg::BK_CLEAR;
                  end
               endcase
            end
         end
         wdct_pkg::BK_EXEC: begin
            // read data for cur_ff arrived in rd_data_ff
            if (cur_ff.op == wdct_pkg::OP_DOC) begin
               mem_we = 1'b1;
               mem_wd = rd_data_ff + cur_ff.weight;
            end else begin
               res_push      = 1'b1;
               res.doc_index = cur_ff.doc_id;
               res.score     = score;
               res.selected  = (score >= 64'(cfg.threshold));
            end
            state_in = wdct_pkg::BK_IDLE;
         end
         wdct_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_addr_ff;
            if (clr_addr_ff == AW'(MAX_DOCS - 1)) begin
               state_in = wdct_pkg::BK_IDLE;
               init_in  = 1'b0;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = wdct_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wdct_pkg::BK_CLEAR;
         total_ff    <= '0;
         clr_addr_ff <= '0;
         init_ff     <= 1'b1;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         clr_addr_ff <= clr_addr_in;
         init_ff     <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   wdct_fifo #(
      .T     (wdct_pkg::wdct_rsp_type),
      .DEPTH (2)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res),
      .full  (res_full),
      .pop   (pop),
      .dout  (rsp_data),
      .empty (empty)
   );

endmodule

// ----- src/weighted_doc_count_threshold.sv -----
// Query path: command queue, registered counter read, result queue; the read is
//   skipped for an id not in use. Row adds 1 per cycle when nothing ahead stalls;
//   an add or query on an id in use takes the registered read, then the write back
//   or result, before the next command. Clear writes one counter per cycle.
// Reset (synchronous, active high) starts a clearing pass over the counter memory;
//   full stays high until it ends. CSR writes are taken.
// ----------------------------------------------------------------------------
// weighted_doc_count_threshold: per-document weighted hit counter
// Front decodes and queues commands, back owns counters and running total,
// a small queue on each side decouples stalls.
// ----------------------------------------------------------------------------
module weighted_doc_count_threshold #(
   parameter int MAX_DOCS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                push,
   input  wdct_pkg::wdct_req_type              req_data,
   output logic                                full,
   // result side
   output logic                                empty,
   input  logic                                pop,
   output wdct_pkg::wdct_rsp_type              rsp_data,
   // config write port
   input  logic                                csr_we,
   input  logic [wdct_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wdct_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [wdct_pkg::CSR_DATA_W-1:0] threshold_ff, threshold_in;
   logic [wdct_pkg::NUM_DOCS_W-1:0] num_docs_ff, num_docs_in;
   logic                            mode_ff, mode_in;

   wdct_pkg::wdct_cfg_type          cfg;
   wdct_pkg::wdct_cmd_type          cmd;
   logic                            cmd_valid;
   logic                            cmd_pop;
   logic                            init_busy;

   // CSR decode; indexes past the list are dropped
   always_comb begin
      threshold_in = threshold_ff;
      num_docs_in  = num_docs_ff;
      mode_in      = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            wdct_pkg::CSR_THRESHOLD: threshold_in = csr_wdata;
            wdct_pkg::CSR_NUM_DOCS:  num_docs_in  = csr_wdata[wdct_pkg::NUM_DOCS_W-1:0];
            wdct_pkg::CSR_MODE:      mode_in      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= wdct_pkg::THRESHOLD_RST;
         num_docs_ff  <= wdct_pkg::NUM_DOCS_RST;
         mode_ff      <= wdct_pkg::MODE_RST;
      end else begin
         threshold_ff <= threshold_in;
         num_docs_ff  <= num_docs_in;
         mode_ff      <= mode_in;
      end
   end

   // zero threshold compares as one
   always_comb begin
      cfg.threshold = (threshold_ff == '0) ? 32'd1 : threshold_ff;
      cfg.num_docs  = num_docs_ff;
      cfg.mode      = mode_ff;
   end

   wdct_front #(
      .MAX_DOCS (MAX_DOCS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cfg       (cfg),
      .init_busy (init_busy),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   wdct_back #(
      .MAX_DOCS (MAX_DOCS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .init_busy (init_busy),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .pop       (pop)
   );

endmodule

// ----- src/wdct_checker.sv -----
// ----------------------------------------------------------------------------
// wdct_checker: port-level checks
// Watches the top level's beats over time; bound to the top level.
// ----------------------------------------------------------------------------
module wdct_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input wdct_pkg::wdct_rsp_type rsp_data
);

   // counter sweep runs right after reset, so no request beat is taken
   a_full_after_reset: assert property (@(posedge clock)
      $past(reset) |-> full)
      else $error("request side open during post-reset sweep");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result beat changed");

   // effective threshold is at least one
   a_sel_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.selected) |-> (rsp_data.score != '0))
      else $error("selected with zero score");

endmodule

bind weighted_doc_count_threshold wdct_checker u_wdct_checker (.*);

// ----- sim/tb_weighted_doc_count_threshold.sv -----
// ----------------------------------------------------------------------------
// tb_weighted_doc_count_threshold: self-checking bench for the doc counter
// A directed table covers the edge cases, then random phases under changing
// configurations. An in-bench model predicts results the table rows do not give.
// ----------------------------------------------------------------------------
module tb_weighted_doc_count_threshold;

   localparam int MAX_DOCS        = 4096;
   localparam int NUM_PHASES      = 16;
   localparam int BEATS_PER_PHASE = 100;
   localparam int CALM_PHASE      = 13;      // from here on, no idling
   localparam int HOLD_OFF_CYCLES = 400;     // long result-side stall
   localparam int TAIL_CYCLES     = 16;      // margin after the last result
   localparam int CYCLE_LIMIT     = 4000000;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // DUT inputs start at known values
   logic                   push      = 1'b0;
   wdct_pkg::wdct_req_type req_data  = '0;
   logic                   pop       = 1'b0;
   logic                   csr_we    = 1'b0;
   logic [wdct_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [wdct_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic                   full;
   logic                   empty;
   wdct_pkg::wdct_rsp_type rsp_data;

   weighted_doc_count_threshold #(
      .MAX_DOCS (MAX_DOCS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Scoreboard model: counters, running total and the register shadow
   // ------------------------------------------------------------------------
   logic [wdct_pkg::COUNT_W-1:0]    hits [MAX_DOCS];
   logic [wdct_pkg::TOTAL_W-1:0]    total_weight = '0;
   logic [wdct_pkg::CSR_DATA_W-1:0] cfg_threshold = wdct_pkg::THRESHOLD_RST;
   logic [wdct_pkg::NUM_DOCS_W-1:0] cfg_num_docs  = wdct_pkg::NUM_DOCS_RST;
   logic                            cfg_mode      = wdct_pkg::MODE_RST;

   wdct_pkg::wdct_rsp_type pending_scores [$];   // queries accepted, result not yet seen

   int  err_count   = 0;
   int  cycle_count = 0;
   bit  tx_idle_on  = 1'b0;
   bit  rx_idle_on  = 1'b1;
   bit  hold_req    = 1'b0;            // asks the result side for a long stall

   initial begin
      foreach (hits[i]) hits[i] = '0;
   end

   // Applies one accepted beat to the model; a query yields its result.
   function automatic void tally_beat(input wdct_pkg::wdct_req_type b,
                                      output bit has_rsp,
                                      output wdct_pkg::wdct_rsp_type r);
      logic                         in_use;
      logic [wdct_pkg::TOTAL_W-1:0] cnt;
      logic [wdct_pkg::TOTAL_W-1:0] thr;
      in_use  = (b.doc_id < cfg_num_docs) && (b.doc_id < MAX_DOCS);
      has_rsp = 1'b0;
      r       = '0;
      case (b.opcode)
         wdct_pkg::OP_ROW: begin
            total_weight = total_weight + wdct_pkg::TOTAL_W'(b.weight);
         end
         wdct_pkg::OP_DOC: begin
            if (in_use) hits[b.doc_id] = hits[b.doc_id] + b.weight;
         end
         wdct_pkg::OP_QUERY: begin
            has_rsp     = 1'b1;
            r.doc_index = b.doc_id;
            if (in_use) begin
               // zero threshold compares as one
               thr = (cfg_threshold == '0) ? wdct_pkg::TOTAL_W'(1) :
                                             wdct_pkg::TOTAL_W'(cfg_threshold);
               cnt = wdct_pkg::TOTAL_W'(hits[b.doc_id]);
               // absence score wraps when the counter exceeds the total
               r.score    = cfg_mode ? (total_weight - cnt) : cnt;
               r.selected = (r.score >= thr);
            end
         end
         default: begin
            // clear: counters and total, registers kept
            foreach (hits[i]) hits[i] = '0;
            total_weight = '0;
         end
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      err_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request side: drive one beat, hold it until taken, then predict
   // ------------------------------------------------------------------------
   task automatic send_beat(input wdct_pkg::wdct_req_type b, input bit typed,
                            input wdct_pkg::wdct_rsp_type typed_rsp);
      bit                     has_rsp;
      wdct_pkg::wdct_rsp_type r;
      push     <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      tally_beat(b, has_rsp, r);
      if (has_rsp) pending_scores.insert(pending_scores.size(), typed ? typed_rsp : r);
   endtask

   // csr_we stays up across back-to-back writes; the last one drops it
   task automatic write_reg(input logic [wdct_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wdct_pkg::CSR_DATA_W-1:0] val, input bit last);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         wdct_pkg::CSR_THRESHOLD: cfg_threshold = val;
         wdct_pkg::CSR_NUM_DOCS:  cfg_num_docs  = val[wdct_pkg::NUM_DOCS_W-1:0];
         wdct_pkg::CSR_MODE:      cfg_mode      = val[0];
         default: ;
      endcase
      if (last) csr_we <= 1'b0;
   endtask

   // Idle point for register writes: all results in, and long enough for a
   // clear running in the back end plus two more queued behind it to finish.
   task automatic settle();
      push <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (3 * (MAX_DOCS + 1) + TAIL_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------------
   typedef struct {
      bit                              is_cfg;
      logic [1:0]                      code;   // opcode, or register index on csr rows
      logic [wdct_pkg::DOC_ID_W-1:0]   doc;
      logic [wdct_pkg::CSR_DATA_W-1:0] value;  // weight, or register data
      bit                              typed;  // expected result written in the row
      logic                            want_sel;
      logic [wdct_pkg::TOTAL_W-1:0]    want_score;
   } stim_row_type;

   stim_row_type stim_rows [$];

   task automatic add_beat(input wdct_pkg::wdct_op_type op,
                           input logic [wdct_pkg::DOC_ID_W-1:0] doc,
                           input logic [wdct_pkg::WEIGHT_W-1:0] w);
      stim_row_type row;
      row       = '{default: '0};
      row.code  = op;
      row.doc   = doc;
      row.value = w;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   task automatic add_known(input logic [wdct_pkg::DOC_ID_W-1:0] doc, input logic sel,
                            input logic [wdct_pkg::TOTAL_W-1:0] score);
      stim_row_type row;
      row            = '{default: '0};
      row.code       = wdct_pkg::OP_QUERY;
      row.doc        = doc;
      row.typed      = 1'b1;
      row.want_sel   = sel;
      row.want_score = score;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   task automatic add_csr(input logic [wdct_pkg::CSR_IDX_W-1:0] idx,
                          input logic [wdct_pkg::CSR_DATA_W-1:0] val);
      stim_row_type row;
      row        = '{default: '0};
      row.is_cfg = 1'b1;
      row.code   = idx;
      row.value  = val;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      wdct_pkg::wdct_req_type          b;
      wdct_pkg::wdct_rsp_type          known;
      logic [wdct_pkg::CSR_DATA_W-1:0] thr;
      logic [wdct_pkg::NUM_DOCS_W-1:0] nd;
      logic                            md;
      int                              pick;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values: threshold 1, all docs in use, presence mode
      add_known(12'd0, 1'b0, 64'd0);                 // fresh counters read zero
      add_known(12'hFFF, 1'b0, 64'd0);
      add_beat(wdct_pkg::OP_DOC, 12'd0, 32'hFFFF_FFFF);
      add_known(12'd0, 1'b1, 64'h0000_0000_FFFF_FFFF);
      add_beat(wdct_pkg::OP_DOC, 12'd0, 32'd1);      // counter wraps to zero
      add_known(12'd0, 1'b0, 64'd0);
      add_beat(wdct_pkg::OP_DOC, 12'hFFF, 32'd1);    // top doc id
      add_known(12'hFFF, 1'b1, 64'd1);
      add_beat(wdct_pkg::OP_ROW, 12'd0, 32'hFFFF_FFFF);
      add_beat(wdct_pkg::OP_ROW, 12'd0, 32'hFFFF_FFFF);
      add_beat(wdct_pkg::OP_DOC, 12'hAAA, 32'h5555_5555);
      add_beat(wdct_pkg::OP_QUERY, 12'hAAA, 32'd0);
      add_beat(wdct_pkg::OP_CLEAR, 12'd0, 32'd0);
      add_known(12'hAAA, 1'b0, 64'd0);               // gone after clear
      // zero threshold acts as one
      add_csr(wdct_pkg::CSR_THRESHOLD, 32'd0);
      add_beat(wdct_pkg::OP_DOC, 12'h555, 32'd1);
      add_known(12'h555, 1'b1, 64'd1);
      // absence mode, including a counter above the total
      add_csr(wdct_pkg::CSR_MODE, 32'd1);
      add_beat(wdct_pkg::OP_ROW, 12'd0, 32'd10);
      add_beat(wdct_pkg::OP_QUERY, 12'h555, 32'd0);
      add_beat(wdct_pkg::OP_DOC, 12'd3, 32'hAAAA_AAAA);
      add_beat(wdct_pkg::OP_QUERY, 12'd3, 32'd0);
      // one doc in use: adds to others dropped, queries on others give zero
      add_csr(wdct_pkg::CSR_NUM_DOCS, 32'd1);
      add_beat(wdct_pkg::OP_DOC, 12'd0, 32'd7);
      add_beat(wdct_pkg::OP_DOC, 12'd3, 32'd7);
      add_known(12'd3, 1'b0, 64'd0);
      add_beat(wdct_pkg::OP_QUERY, 12'd0, 32'd0);
      add_csr(wdct_pkg::CSR_THRESHOLD, 32'hFFFF_FFFF);
      add_beat(wdct_pkg::OP_QUERY, 12'd0, 32'd0);
      add_known(12'h555, 1'b0, 64'd0);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg) begin
            settle();
            write_reg(stim_rows[i].code, stim_rows[i].value, 1'b1);
         end else begin
            b.opcode        = stim_rows[i].code;
            b.doc_id        = stim_rows[i].doc;
            b.weight        = stim_rows[i].value;
            known.doc_index = stim_rows[i].doc;
            known.selected  = stim_rows[i].want_sel;
            known.score     = stim_rows[i].want_score;
            send_beat(b, stim_rows[i].typed, known);
         end
      end

      // random phases, each under its own register setting
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin thr = 32'd1;          nd = 13'd4096; md = 1'b0; end
            1: begin thr = 32'hFFFF_FFFF;  nd = 13'd4096; md = 1'b1; end
            2: begin thr = 32'd0;          nd = 13'd1;    md = 1'b0; end
            3: begin thr = 32'd20;         nd = 13'd4095; md = 1'b0; end
            4: begin thr = 32'hFFFF_FFFF;  nd = 13'd2;    md = 1'b0; end
            5: begin thr = 32'd50;         nd = 13'd9;    md = 1'b1; end
            default: begin
               pick = $urandom_range(0, 4);
               thr  = (pick == 0) ? 32'd0 :
                      (pick == 1) ? 32'd1 :
                      (pick == 2) ? 32'($urandom_range(1, 300)) :
                      (pick == 3) ? 32'($urandom) : 32'hFFFF_FFFF;
               pick = $urandom_range(0, 3);
               nd   = (pick == 0) ? 13'd1 :
                      (pick == 1) ? 13'd4096 :
                      (pick == 2) ? 13'($urandom_range(2, 64)) :
                                    13'($urandom_range(1, 4096));
               md   = 1'($urandom_range(0, 1));
            end
         endcase
         settle();
         write_reg(wdct_pkg::CSR_THRESHOLD, thr, 1'b0);
         write_reg(wdct_pkg::CSR_NUM_DOCS, 32'(nd), 1'b0);
         write_reg(wdct_pkg::CSR_MODE, 32'(md), 1'b1);

         // phase 0 runs back to back against a stalled result side so the
         // block fills up; every fourth phase and the tail run without gaps
         tx_idle_on = (phase != 0) && (phase % 4 != 3) && (phase < CALM_PHASE);
         rx_idle_on = (phase % 4 != 3) && (phase < CALM_PHASE);
         if (phase == 0) hold_req = 1'b1;

         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 999);
            b.opcode = (pick < 10)  ? wdct_pkg::OP_CLEAR :
                       (pick < 220) ? wdct_pkg::OP_ROW :
                       (pick < 600) ? wdct_pkg::OP_DOC : wdct_pkg::OP_QUERY;
            // mostly a few hot docs so counters build up, some near the
            // in-use boundary, the rest anywhere
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               b.doc_id = wdct_pkg::DOC_ID_W'($urandom_range(0, 7));
            end else if (pick < 75) begin
               b.doc_id = wdct_pkg::DOC_ID_W'(nd - 13'd4 +
                             wdct_pkg::NUM_DOCS_W'($urandom_range(0, 7)));
            end else begin
               b.doc_id = wdct_pkg::DOC_ID_W'($urandom_range(0, 4095));
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               b.weight = wdct_pkg::WEIGHT_W'($urandom_range(0, 40));
            end else if (pick < 80) begin
               b.weight = wdct_pkg::WEIGHT_W'($urandom);
            end else if (pick < 95) begin
               b.weight = 32'hFFFF_FFF0 | wdct_pkg::WEIGHT_W'($urandom_range(0, 15));
            end else begin
               b.weight = '0;
            end

            if (tx_idle_on && $urandom_range(0, 3) == 0) begin
               push <= 1'b0;
               repeat ($urandom_range(1, 18)) @(posedge clock);
            end
            send_beat(b, 1'b0, known);
         end
      end

      push <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side: pop with random stall bursts, plus one long hold-off
   // ------------------------------------------------------------------------
   always begin
      if (hold_req) begin
         pop <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         pop <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end else begin
         pop <= 1'b1;
         @(posedge clock);
      end
   end

   // each result beat against the oldest pending query
   always @(posedge clock) begin : rsp_check
      wdct_pkg::wdct_rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_scores.size() == 0) begin
            note_mismatch($sformatf("result beat with no query pending, doc %0d",
                                    rsp_data.doc_index));
         end else begin
            want = pending_scores.pop_front();
            if (rsp_data.doc_index !== want.doc_index)
               note_mismatch($sformatf("doc_index got %0d want %0d",
                                       rsp_data.doc_index, want.doc_index));
            if (rsp_data.selected !== want.selected)
               note_mismatch($sformatf("doc %0d selected got %0b want %0b",
                                       want.doc_index, rsp_data.selected, want.selected));
            if (rsp_data.score !== want.score)
               note_mismatch($sformatf("doc %0d score got %h want %h",
                                       want.doc_index, rsp_data.score, want.score));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
